// ----- rtl/pet_pkg.sv -----
`default_nettype none

package pet_pkg;

	localparam int unsigned SampleW = 16;
	localparam int unsigned GainW = 16;
	localparam int unsigned IntegW = 32;
	localparam int unsigned DerivW = 17;
	localparam int unsigned CountW = 16;
	localparam int unsigned SqW = 48;
	localparam int unsigned SqProdW = 32;
	localparam int unsigned DriveW = 24;
	localparam int unsigned CfgIndexW = 8;

	localparam logic [CfgIndexW-1:0] REG_PROP_GAIN = 8'd0;
	localparam logic [CfgIndexW-1:0] REG_INTEG_GAIN = 8'd1;
	localparam logic [CfgIndexW-1:0] REG_DERIV_GAIN = 8'd2;
	localparam logic [CfgIndexW-1:0] REG_SETTLE_SAMPLES = 8'd3;

	localparam logic [CountW-1:0] SETTLE_RESET = 16'd100;

	typedef struct packed {
		logic signed [SampleW-1:0] error_sample;
		logic start_run;
	} in_item_t;

	typedef struct packed {
		logic signed [DriveW-1:0] drive_value;
		logic [SqW-1:0] sq_error_total;
		logic [CountW-1:0] samples_seen;
	} out_item_t;

	typedef struct packed {
		logic signed [GainW-1:0] prop_gain;
		logic signed [GainW-1:0] integ_gain;
		logic signed [GainW-1:0] deriv_gain;
		logic [CountW-1:0] settle_samples;
	} cfg_t;

	typedef struct packed {
		logic signed [SampleW-1:0] error_sample;
		logic signed [IntegW-1:0] integral;
		logic signed [DerivW-1:0] deriv;
		logic [SqW-1:0] sq_total;
		logic [CountW-1:0] count;
	} upd_t;

endpackage

`default_nettype wire

// ----- rtl/pet_cfg_regs.sv -----
`default_nettype none

module pet_cfg_regs (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [pet_pkg::CfgIndexW-1:0] cfg_index,
	input  wire logic [pet_pkg::GainW-1:0] cfg_data,
	output pet_pkg::cfg_t cfg
);
	import pet_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain <= '0;
			cfg_q.integ_gain <= '0;
			cfg_q.deriv_gain <= '0;
			cfg_q.settle_samples <= SETTLE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PROP_GAIN: cfg_q.prop_gain <= cfg_data;
				REG_INTEG_GAIN: cfg_q.integ_gain <= cfg_data;
				REG_DERIV_GAIN: cfg_q.deriv_gain <= cfg_data;
				REG_SETTLE_SAMPLES: cfg_q.settle_samples <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pet_update.sv -----
`default_nettype none

module pet_update (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire pet_pkg::in_item_t in_data,
	input  wire logic [pet_pkg::CountW-1:0] settle_samples,
	output logic upd_valid,
	input  wire logic upd_ready,
	output pet_pkg::upd_t upd_data
);
	import pet_pkg::*;

	logic v_s1;
	logic signed [SampleW-1:0] e_s1;
	logic start_s1;
	logic [SqProdW-1:0] sq_s1;

	logic v_s2;
	upd_t upd_s2;

	logic signed [IntegW-1:0] integral_q;
	logic signed [SampleW-1:0] prev_q;
	logic [CountW-1:0] count_q;
	logic [SqW-1:0] sq_sum_q;

	logic ready1, ready2, adv1;
	logic signed [SqProdW-1:0] sq_c;

	logic signed [IntegW-1:0] base_int;
	logic signed [SampleW-1:0] base_prev;
	logic [CountW-1:0] base_cnt;
	logic [SqW-1:0] base_sq;
	logic signed [IntegW:0] int_sum;
	logic signed [IntegW-1:0] int_new;
	logic signed [DerivW-1:0] d_new;
	logic [CountW-1:0] cnt_new;
	logic [SqW:0] sq_sum;
	logic [SqW-1:0] sq_new;

	function automatic logic signed [SqProdW-1:0] e_sq(input logic signed [SampleW-1:0] e);
		logic signed [SqProdW-1:0] ex;
		ex = SqProdW'(e);
		return ex * ex;
	endfunction

	assign ready2 = !v_s2 || upd_ready;
	assign ready1 = !v_s1 || ready2;
	assign adv1 = v_s1 && ready2;
	assign in_stall = !ready1;
	assign upd_valid = v_s2;
	assign upd_data = upd_s2;

	assign sq_c = e_sq(in_data.error_sample);

	always_comb begin
		base_int = start_s1 ? '0 : integral_q;
		base_prev = start_s1 ? '0 : prev_q;
		base_cnt = start_s1 ? '0 : count_q;
		base_sq = start_s1 ? '0 : sq_sum_q;

		int_sum = (IntegW+1)'(base_int) + (IntegW+1)'(e_s1);
		if (int_sum[IntegW] != int_sum[IntegW-1]) begin
			int_new = int_sum[IntegW] ? {1'b1, {(IntegW-1){1'b0}}} : {1'b0, {(IntegW-1){1'b1}}};
		end else begin
			int_new = int_sum[IntegW-1:0];
		end

		if (base_cnt == '0) begin
			d_new = '0;
		end else begin
			d_new = DerivW'(e_s1) - DerivW'(base_prev);
		end

		cnt_new = (base_cnt == '1) ? base_cnt : base_cnt + 1'b1;

		sq_sum = {1'b0, base_sq} + {{(SqW+1-SqProdW){1'b0}}, sq_s1};
		if (cnt_new > settle_samples) begin
			sq_new = sq_sum[SqW] ? '1 : sq_sum[SqW-1:0];
		end else begin
			sq_new = base_sq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			integral_q <= '0;
			prev_q <= '0;
			count_q <= '0;
			sq_sum_q <= '0;
		end else begin
			if (ready1) begin
				v_s1 <= in_valid;
			end
			if (ready2) begin
				v_s2 <= v_s1;
			end
			if (adv1) begin
				integral_q <= int_new;
				prev_q <= e_s1;
				count_q <= cnt_new;
				sq_sum_q <= sq_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready1) begin
			e_s1 <= in_data.error_sample;
			start_s1 <= in_data.start_run;
			sq_s1 <= sq_c;
		end
		if (adv1) begin
			upd_s2.error_sample <= e_s1;
			upd_s2.integral <= int_new;
			upd_s2.deriv <= d_new;
			upd_s2.sq_total <= sq_new;
			upd_s2.count <= cnt_new;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pet_drive.sv -----
`default_nettype none

module pet_drive (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic upd_valid,
	output logic upd_ready,
	input  wire pet_pkg::upd_t upd_data,
	input  wire pet_pkg::cfg_t cfg,
	output logic out_valid,
	input  wire logic out_stall,
	output pet_pkg::out_item_t out_data
);
	import pet_pkg::*;

	localparam int unsigned PW = GainW + SampleW;
	localparam int unsigned IW = GainW + IntegW;
	localparam int unsigned DW = GainW + DerivW;
	localparam int unsigned AccW = IW + 2;

	logic v_s3;
	logic signed [PW-1:0] p_s3;
	logic signed [IW-1:0] i_s3;
	logic signed [DW-1:0] d_s3;
	logic [SqW-1:0] sq_s3;
	logic [CountW-1:0] cnt_s3;

	logic vo_q;
	out_item_t out_q;

	logic ready_o, ready3;
	logic signed [PW-1:0] p_c;
	logic signed [IW-1:0] i_c;
	logic signed [DW-1:0] d_c;
	logic signed [AccW-1:0] acc, neg, rnd, shr;
	logic signed [DriveW-1:0] drive_c;

	assign ready_o = !vo_q || !out_stall;
	assign ready3 = !v_s3 || ready_o;
	assign upd_ready = ready3;
	assign out_valid = vo_q;
	assign out_data = out_q;

	always_comb begin
		p_c = PW'(cfg.prop_gain) * PW'(upd_data.error_sample);
		i_c = IW'(cfg.integ_gain) * IW'(upd_data.integral);
		d_c = DW'(cfg.deriv_gain) * DW'(upd_data.deriv);
	end

	always_comb begin
		acc = AccW'(p_s3) + AccW'(i_s3) + AccW'(d_s3);
		neg = -acc;
		rnd = neg + AccW'(signed'(128));
		shr = rnd >>> 8;
		if (shr > AccW'(signed'(8388607))) begin
			drive_c = {1'b0, {(DriveW-1){1'b1}}};
		end else if (shr < -AccW'(signed'(8388608))) begin
			drive_c = {1'b1, {(DriveW-1){1'b0}}};
		end else begin
			drive_c = shr[DriveW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (ready3) begin
				v_s3 <= upd_valid;
			end
			if (ready_o) begin
				vo_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_valid && ready3) begin
			p_s3 <= p_c;
			i_s3 <= i_c;
			d_s3 <= d_c;
			sq_s3 <= upd_data.sq_total;
			cnt_s3 <= upd_data.count;
		end
		if (v_s3 && ready_o) begin
			out_q.drive_value <= drive_c;
			out_q.sq_error_total <= sq_s3;
			out_q.samples_seen <= cnt_s3;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pid_error_tracker.sv -----
// PID error tracker: one Q8.8 error sample per input transaction, one result
// transaction per sample carrying the negated, saturated PID drive value, the
// squared-error total and the sample count of the current run.
// The input and output channels use valid and stall; a transaction completes
// on a rising edge where valid is high and stall is low. The configuration
// channel uses valid and ready, ready is always high, and writes the gains
// and the settle threshold by register index; unknown indexes are ignored.
// The datapath is a four-register pipeline: input register with the e*e
// product, state update, gain products, then the summed and rounded result in
// the output register. One sample is taken in every cycle while in_stall is low.
// Each stage holds its contents while the next is full, so a stall on the
// output lets the earlier stages keep filling; the input stalls only once all
// four stages hold results.
// Reset clears the run state and empties the pipeline; the gains reset to zero
// and the settle threshold to 100. A sample with start_run set clears the run
// state before it is applied.
`default_nettype none

module pid_error_tracker (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire pet_pkg::in_item_t in_data,
	output logic out_valid,
	input  wire logic out_stall,
	output pet_pkg::out_item_t out_data,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [pet_pkg::CfgIndexW-1:0] cfg_index,
	input  wire logic [pet_pkg::GainW-1:0] cfg_data
);
	import pet_pkg::*;

	cfg_t cfg;
	logic upd_valid, upd_ready;
	upd_t upd_data;

	pet_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	pet_update u_update (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.settle_samples(cfg.settle_samples),
		.upd_valid(upd_valid),
		.upd_ready(upd_ready),
		.upd_data(upd_data)
	);

	pet_drive u_drive (
		.clk(clk),
		.arst_n(arst_n),
		.upd_valid(upd_valid),
		.upd_ready(upd_ready),
		.upd_data(upd_data),
		.cfg(cfg),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.samples_seen != '0)
		else $error("result transaction with a zero sample count");

	a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || !out_stall) |-> !in_stall)
		else $error("input stalled while the output side can move");

	a_first_sq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.samples_seen == 16'd1) |->
		out_data.sq_error_total <= 48'h0000_4000_0000)
		else $error("squared-error total too large on the first sample of a run");

endmodule

`default_nettype wire

// ----- sim/pid_result_checker.sv -----
`timescale 1ns / 100ps

module pid_result_checker
	import pet_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire in_item_t in_data,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire out_item_t out_data,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [CfgIndexW-1:0] cfg_index,
	input wire logic [GainW-1:0] cfg_data,
	output int fail_count,
	output int pending
);

	localparam longint IntegMax = 64'sd2147483647;
	localparam longint IntegMin = -64'sd2147483648;
	localparam longint DriveMax = 64'sd8388607;
	localparam longint DriveMin = -64'sd8388608;
	localparam logic [63:0] SqMax = 64'h0000_FFFF_FFFF_FFFF;

	logic signed [GainW-1:0] kp, ki, kd;
	logic [CountW-1:0] settle;

	logic signed [IntegW-1:0] integ_acc;
	logic signed [SampleW-1:0] last_err;
	logic [CountW-1:0] run_count;
	logic [SqW-1:0] sq_acc;

	out_item_t predicted_results[$];
	out_item_t want;

	function automatic out_item_t pid_update(input in_item_t item);
		longint e, isum, d, acc, drive;
		logic [63:0] sq;
		out_item_t res;
		e = longint'(signed'(item.error_sample));
		if (item.start_run) begin
			integ_acc = '0;
			last_err = '0;
			run_count = '0;
			sq_acc = '0;
		end
		isum = longint'(integ_acc) + e;
		if (isum > IntegMax) begin
			isum = IntegMax;
		end
		if (isum < IntegMin) begin
			isum = IntegMin;
		end
		integ_acc = isum[IntegW-1:0];
		d = (run_count == '0) ? 64'sd0 : e - longint'(last_err);
		last_err = item.error_sample;
		if (run_count != '1) begin
			run_count = run_count + 1'b1;
		end
		if (run_count > settle) begin
			sq = e * e;
			if ({16'd0, sq_acc} > SqMax - sq) begin
				sq_acc = SqMax[SqW-1:0];
			end else begin
				sq_acc = sq_acc + sq[SqW-1:0];
			end
		end
		acc = longint'(kp) * e + longint'(ki) * isum + longint'(kd) * d;
		// Round half up on the way from Q.20 to Q12.12.
		drive = (64'sd128 - acc) >>> 8;
		if (drive > DriveMax) begin
			drive = DriveMax;
		end
		if (drive < DriveMin) begin
			drive = DriveMin;
		end
		res.drive_value = drive[DriveW-1:0];
		res.sq_error_total = sq_acc;
		res.samples_seen = run_count;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp = '0;
			ki = '0;
			kd = '0;
			settle = SETTLE_RESET;
			integ_acc = '0;
			last_err = '0;
			run_count = '0;
			sq_acc = '0;
			predicted_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PROP_GAIN: kp = cfg_data;
					REG_INTEG_GAIN: ki = cfg_data;
					REG_DERIV_GAIN: kd = cfg_data;
					REG_SETTLE_SAMPLES: settle = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (predicted_results.size() == 0) begin
					$display("%0t: result transaction with none expected, actual %p", $time,
						out_data);
					fail_count++;
				end else begin
					want = predicted_results.pop_front();
					if (out_data.drive_value !== want.drive_value) begin
						$display("%0t: drive_value expected %0d, actual %0d", $time,
							want.drive_value, out_data.drive_value);
						fail_count++;
					end
					if (out_data.sq_error_total !== want.sq_error_total) begin
						$display("%0t: sq_error_total expected %0d, actual %0d", $time,
							want.sq_error_total, out_data.sq_error_total);
						fail_count++;
					end
					if (out_data.samples_seen !== want.samples_seen) begin
						$display("%0t: samples_seen expected %0d, actual %0d", $time,
							want.samples_seen, out_data.samples_seen);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				predicted_results.push_back(pid_update(in_data));
			end
			pending = predicted_results.size();
		end
	end

endmodule

// ----- sim/pid_error_tracker_tb.sv -----
`timescale 1ns / 100ps

module pid_error_tracker_tb;
	import pet_pkg::*;

	localparam int CycleLimit = 100000;
	localparam int DrainCycles = 8;
	localparam int HoldCycles = 100;
	localparam int SegmentItems = 122;
	localparam int MaxSettleItems = 19;
	localparam int NegRunItems = 20;
	localparam int PosRunItems = 19;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [GainW-1:0] cfg_data = '0;

	int fail_count;
	int pending;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic hold_req = 1'b0;
	logic hold_ack = 1'b0;

	pid_error_tracker i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	pid_result_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// The receiver stalls at random, or holds off completely for a long stretch on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req != hold_ack) begin
				hold_ack = hold_req;
				out_stall <= 1'b1;
				for (int n = 0; n < HoldCycles; n++) begin
					@(negedge clk);
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	function automatic logic signed [SampleW-1:0] pick_sample();
		case ($urandom_range(9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2, 3: return SampleW'($urandom_range(511)) - 16'sd256;
			default: return SampleW'($urandom);
		endcase
	endfunction

	function automatic logic [GainW-1:0] pick_gain();
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3, 4, 5: return GainW'($urandom_range(16383)) - 16'd8192;
			default: return GainW'($urandom);
		endcase
	endfunction

	function automatic logic [CountW-1:0] pick_settle();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return CountW'($urandom);
			default: return CountW'($urandom_range(20));
		endcase
	endfunction

	task automatic send_sample(input logic signed [SampleW-1:0] e, input logic start);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{error_sample: e, start_run: start};
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic cfg_write(input logic [CfgIndexW-1:0] idx, input logic [GainW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic load_gains(input logic [GainW-1:0] p, input logic [GainW-1:0] i,
		input logic [GainW-1:0] d, input logic [CountW-1:0] s);
		wait_idle();
		cfg_write(REG_PROP_GAIN, p);
		cfg_write(REG_INTEG_GAIN, i);
		cfg_write(REG_DERIV_GAIN, d);
		cfg_write(REG_SETTLE_SAMPLES, s);
		// A write to an unused index must leave every register alone.
		cfg_write(CfgIndexW'($urandom_range(255, REG_SETTLE_SAMPLES + 1)), GainW'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int segments);
		for (int s = 0; s < segments; s++) begin
			load_gains(pick_gain(), pick_gain(), pick_gain(), pick_settle());
			for (int n = 0; n < SegmentItems; n++) begin
				send_sample(pick_sample(), $urandom_range(99) < 3);
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 21;
		recv_idle_pct = 81;

		// Reset values: zero gains, threshold of 100.
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b0);

		load_gains(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'sh0001, 1'b0);
		send_sample(16'shFFFF, 1'b0);
		send_sample(16'sh8000, 1'b1);

		load_gains(16'h8000, 16'h7FFF, 16'h8000, 16'h0003);
		send_sample(16'sh7FFF, 1'b1);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh7FFF, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'sh0080, 1'b0);
		send_sample(16'shFF80, 1'b0);

		// Smallest proportional gain puts the rounding on exact halves.
		load_gains(16'h0001, 16'h0000, 16'h0000, 16'h0001);
		send_sample(16'sh0080, 1'b1);
		send_sample(16'shFF80, 1'b0);
		send_sample(16'sh007F, 1'b0);
		send_sample(16'shFF7F, 1'b0);

		random_phase(5);

		wait_idle();
		send_idle_pct = 81;
		recv_idle_pct = 21;
		random_phase(5);

		wait_idle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(5);

		// Long hold-off on the output while samples keep coming, so the pipeline fills up.
		hold_req = ~hold_req;
		for (int n = 0; n < 40; n++) begin
			send_sample(pick_sample(), 1'b0);
		end

		// With the threshold at its maximum nothing is accumulated.
		load_gains(pick_gain(), pick_gain(), pick_gain(), 16'hFFFF);
		send_sample(pick_sample(), 1'b1);
		for (int n = 0; n < MaxSettleItems; n++) begin
			send_sample(pick_sample(), 1'b0);
		end

		// Runs of samples at both limits.
		load_gains(pick_gain(), pick_gain(), pick_gain(), 16'h0000);
		send_sample(16'sh8000, 1'b1);
		for (int n = 0; n < NegRunItems; n++) begin
			send_sample(16'sh8000, 1'b0);
		end
		for (int n = 0; n < PosRunItems; n++) begin
			send_sample(16'sh7FFF, 1'b0);
		end

		wait_idle();
		if (fail_count == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
